// ===== src/fsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the frustum sphere cull block.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int MASK_BITS = 12;
  localparam int CNT_W     = $clog2(MASK_BITS + 1);
  localparam int VIS_W     = 2;
  localparam int DIST_W    = 66;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd0;
  localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
  localparam logic [VIS_W-1:0] VIS_FULL    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;     // write the plane of the accepted request into the store
    logic start;    // capture the sphere of the accepted request
    logic issue;    // send the next plane into the pipeline
    logic publish;  // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic issue_done;  // every active plane has been sent
    logic pipe_busy;   // a plane is still in flight
    logic out_full;    // the output register holds a result that is not taken
  } status_t;

endpackage
`default_nettype wire

// ===== src/fsc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_ctrl
// Sequencer: accepts requests, walks the planes and hands off the result.
// ----------------------------------------------------------------------------
module fsc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            func,
  output logic                 in_stall,
  output fsc_pkg::cmd_t        cmd,
  input  fsc_pkg::status_t     status
);
  import fsc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (func == FUNC_TEST) begin
            cmd.start  = 1'b1;
            state_next = ST_RUN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (status.issue_done) begin
          state_next = ST_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && !status.out_full) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/fsc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsc_datapath
// Plane store, plane counter, distance pipeline, mask update and output
// register.
// ----------------------------------------------------------------------------
module fsc_datapath #(
  parameter int MAX_PLANES = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  fsc_pkg::cmd_t                     cmd,
  output fsc_pkg::status_t                  status,
  input  wire logic                         cfg_wr_en,
  input  wire logic [3:0]                   cfg_wr_data,
  input  wire logic [3:0]                   plane_index,
  input  wire logic signed [31:0]           load_normal_x,
  input  wire logic signed [31:0]           load_normal_y,
  input  wire logic signed [31:0]           load_normal_z,
  input  wire logic signed [31:0]           load_offset,
  input  wire logic signed [31:0]           center_x,
  input  wire logic signed [31:0]           center_y,
  input  wire logic signed [31:0]           center_z,
  input  wire logic [30:0]                  radius,
  input  wire logic [fsc_pkg::MASK_BITS-1:0] mask_in,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic [fsc_pkg::VIS_W-1:0]         visibility,
  output logic [fsc_pkg::MASK_BITS-1:0]     mask_out
);
  import fsc_pkg::*;

  localparam int IDX_W      = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int TEST_LIMIT = (MAX_PLANES < MASK_BITS) ? MAX_PLANES : MASK_BITS;

  // Plane store.
  logic signed [31:0] nx_mem  [MAX_PLANES];
  logic signed [31:0] ny_mem  [MAX_PLANES];
  logic signed [31:0] nz_mem  [MAX_PLANES];
  logic signed [31:0] off_mem [MAX_PLANES];

  logic [3:0]           plane_count;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     cnt;

  // Sphere of the current request.
  logic signed [31:0]     cx;
  logic signed [31:0]     cy;
  logic signed [31:0]     cz;
  logic signed [DIST_W-1:0] rpos;
  logic [MASK_BITS-1:0]   mask_work;
  logic                   outside;

  // Pipeline stages.
  logic                   s1_valid;
  logic [CNT_W-1:0]       s1_idx;
  logic signed [31:0]     rd_nx;
  logic signed [31:0]     rd_ny;
  logic signed [31:0]     rd_nz;
  logic signed [31:0]     rd_off;

  logic                   s2_valid;
  logic [CNT_W-1:0]       s2_idx;
  logic signed [63:0]     prod_x;
  logic signed [63:0]     prod_y;
  logic signed [63:0]     prod_z;
  logic signed [31:0]     s2_off;

  logic                   s3_valid;
  logic [CNT_W-1:0]       s3_idx;
  logic signed [DIST_W-1:0] sum_a;
  logic signed [DIST_W-1:0] sum_b;

  logic                   s4_valid;
  logic [CNT_W-1:0]       s4_idx;
  logic signed [DIST_W-1:0] plane_dist;

  logic signed [DIST_W-1:0] off_term;
  logic                     is_out;
  logic                     is_clear;

  always_comb begin
    if (plane_count > CNT_W'(TEST_LIMIT)) begin
      limit = CNT_W'(TEST_LIMIT);
    end else begin
      limit = plane_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= '0;
    end else if (cfg_wr_en) begin
      plane_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (int'(plane_index) < MAX_PLANES)) begin
      nx_mem[IDX_W'(plane_index)]  <= load_normal_x;
      ny_mem[IDX_W'(plane_index)]  <= load_normal_y;
      nz_mem[IDX_W'(plane_index)]  <= load_normal_z;
      off_mem[IDX_W'(plane_index)] <= load_offset;
    end
    if (cmd.issue) begin
      rd_nx  <= nx_mem[IDX_W'(cnt)];
      rd_ny  <= ny_mem[IDX_W'(cnt)];
      rd_nz  <= nz_mem[IDX_W'(cnt)];
      rd_off <= off_mem[IDX_W'(cnt)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.issue) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx   <= center_x;
      cy   <= center_y;
      cz   <= center_z;
      rpos <= signed'({19'd0, radius, 16'd0});
    end
  end

  // Valid bits of the distance pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  assign off_term = signed'({{(DIST_W - 48){s2_off[31]}}, s2_off, 16'd0});

  always_ff @(posedge clk) begin
    s1_idx     <= cnt;
    s2_idx     <= s1_idx;
    s3_idx     <= s2_idx;
    s4_idx     <= s3_idx;
    prod_x     <= rd_nx * cx;
    prod_y     <= rd_ny * cy;
    prod_z     <= rd_nz * cz;
    s2_off     <= rd_off;
    sum_a      <= DIST_W'(prod_x) + DIST_W'(prod_y);
    sum_b      <= DIST_W'(prod_z) + off_term;
    plane_dist <= sum_a + sum_b;
  end

  assign is_out   = plane_dist > rpos;
  assign is_clear = (plane_dist >= rpos) || (plane_dist <= -rpos);

  // Each plane touches only its own mask bit, and any rejecting plane makes
  // the whole result outside, so the order of evaluation does not matter.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mask_work <= mask_in;
      outside   <= 1'b0;
    end else if (s4_valid && mask_work[s4_idx]) begin
      if (is_out) begin
        outside <= 1'b1;
      end else if (is_clear) begin
        mask_work[s4_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (outside) begin
        visibility <= VIS_OUTSIDE;
        mask_out   <= '0;
      end else begin
        visibility <= (|mask_work) ? VIS_PARTIAL : VIS_FULL;
        mask_out   <= mask_work;
      end
    end
  end

  assign status.issue_done = (cnt >= limit);
  assign status.pipe_busy  = s1_valid | s2_valid | s3_valid | s4_valid;
  assign status.out_full   = out_valid & out_stall;

endmodule
`default_nettype wire

// ===== src/frustum_sphere_cull_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_sphere_cull_top
// Sphere versus view-frustum culling against a store of planes with a mask.
// ----------------------------------------------------------------------------
// The input channel (in_valid / in_stall) carries two kinds of request. A load
// request (func = 0) writes one plane into the store in the cycle it is
// accepted and gives no result. A test request (func = 1) carries a sphere and
// a plane mask and gives one result on the output channel (out_valid /
// out_stall): visibility and the updated mask.
// A test walks the active planes one per cycle through a five-stage distance
// pipeline (store read, three parallel multiplies, two adder stages, compare).
// plane_count sets the number of active planes, capped at MAX_PLANES and at
// MASK_BITS. A load does not leave the idle state, so another request can be
// accepted without a stall. Only one request is in work at a time; in_stall
// is high while a test runs.
// The output register holds a result until it is taken. A new request may be
// accepted while it waits; a following test holds its result until the
// register is free, and a stalled output never loses or changes a result.
// The user must write plane_count through cfg_wr_en / cfg_wr_data only while
// the block idles; the block does not enforce it. Reset clears plane_count,
// the sequencer and out_valid. The plane store is undefined until loaded.
// ----------------------------------------------------------------------------
module frustum_sphere_cull_top #(
  parameter int MAX_PLANES = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [3:0]                    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          func,
  input  wire logic [3:0]                    plane_index,
  input  wire logic signed [31:0]            load_normal_x,
  input  wire logic signed [31:0]            load_normal_y,
  input  wire logic signed [31:0]            load_normal_z,
  input  wire logic signed [31:0]            load_offset,
  input  wire logic signed [31:0]            center_x,
  input  wire logic signed [31:0]            center_y,
  input  wire logic signed [31:0]            center_z,
  input  wire logic [30:0]                   radius,
  input  wire logic [fsc_pkg::MASK_BITS-1:0] mask_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [fsc_pkg::VIS_W-1:0]          visibility,
  output logic [fsc_pkg::MASK_BITS-1:0]      mask_out
);
  import fsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  fsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  fsc_datapath #(
    .MAX_PLANES (MAX_PLANES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .plane_index   (plane_index),
    .load_normal_x (load_normal_x),
    .load_normal_y (load_normal_y),
    .load_normal_z (load_normal_z),
    .load_offset   (load_offset),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .radius        (radius),
    .mask_in       (mask_in),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .visibility    (visibility),
    .mask_out      (mask_out)
  );

endmodule
`default_nettype wire
